[hdl/isva_pkg.sv]
// shared types, operation codes and the divider step for the stack vm alu
package isva_pkg;

    localparam int DataW = 16;
    localparam int FuncW = 5;
    localparam int ShamtW = 8;
    // divide steps per pipeline stage
    localparam int DivStepsPerStage = 4;
    localparam int DivStages = DataW / DivStepsPerStage;

    localparam logic [FuncW-1:0] OP_ADD   = 5'd0;
    localparam logic [FuncW-1:0] OP_SUB   = 5'd1;
    localparam logic [FuncW-1:0] OP_MUL   = 5'd2;
    localparam logic [FuncW-1:0] OP_DIV   = 5'd3;
    localparam logic [FuncW-1:0] OP_MOD   = 5'd4;
    localparam logic [FuncW-1:0] OP_EQ    = 5'd5;
    localparam logic [FuncW-1:0] OP_GT    = 5'd6;
    localparam logic [FuncW-1:0] OP_LT    = 5'd7;
    localparam logic [FuncW-1:0] OP_LE    = 5'd8;
    localparam logic [FuncW-1:0] OP_GE    = 5'd9;
    localparam logic [FuncW-1:0] OP_NE    = 5'd10;
    localparam logic [FuncW-1:0] OP_AND   = 5'd11;
    localparam logic [FuncW-1:0] OP_OR    = 5'd12;
    localparam logic [FuncW-1:0] OP_XOR   = 5'd13;
    localparam logic [FuncW-1:0] OP_MIN   = 5'd14;
    localparam logic [FuncW-1:0] OP_MAX   = 5'd15;
    localparam logic [FuncW-1:0] OP_NOT   = 5'd16;
    localparam logic [FuncW-1:0] OP_ABS   = 5'd17;
    localparam logic [FuncW-1:0] OP_NEG   = 5'd18;
    localparam logic [FuncW-1:0] OP_SHIFT = 5'd19;

    typedef struct packed {
        logic [FuncW-1:0]         func;
        logic signed [DataW-1:0]  left_operand;
        logic signed [DataW-1:0]  right_operand;
        logic signed [ShamtW-1:0] shift_amount;
    } in_word_t;

    typedef struct packed {
        logic signed [DataW-1:0] result_value;
        logic                    result_is_byte;
        logic                    divide_by_zero;
    } out_word_t;

    // magnitude divider state carried through the pipeline
    typedef struct packed {
        logic [DataW-1:0] quo;   // dividend bits shift out, quotient bits shift in
        logic [DataW-1:0] rem;
        logic [DataW-1:0] dvs;
    } div_state_t;

    // one restoring division step
    function automatic div_state_t div_step(div_state_t s);
        div_state_t    n;
        logic [DataW:0] trial;
        logic [DataW:0] part;
        part  = {s.rem, s.quo[DataW-1]};
        trial = part - {1'b0, s.dvs};
        n.dvs = s.dvs;
        if (!trial[DataW]) begin
            n.rem = trial[DataW-1:0];
            n.quo = {s.quo[DataW-2:0], 1'b1};
        end else begin
            n.rem = part[DataW-1:0];
            n.quo = {s.quo[DataW-2:0], 1'b0};
        end
        return n;
    endfunction

endpackage

[hdl/isva_div_pipe.sv]
// pipelined 16-bit unsigned restoring divider, four quotient bits per stage
module isva_div_pipe (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [isva_pkg::DataW-1:0]   dividend,
    input  logic [isva_pkg::DataW-1:0]   divisor,
    output logic [isva_pkg::DataW-1:0]   quotient,
    output logic [isva_pkg::DataW-1:0]   remainder
);

    isva_pkg::div_state_t stage_reg [isva_pkg::DivStages];
    isva_pkg::div_state_t stage_next [isva_pkg::DivStages];

    always_comb begin
        isva_pkg::div_state_t s;
        for (int k = 0; k < isva_pkg::DivStages; k++) begin
            if (k == 0) begin
                s.quo = dividend;
                s.rem = '0;
                s.dvs = divisor;
            end else begin
                s = stage_reg[k-1];
            end
            for (int j = 0; j < isva_pkg::DivStepsPerStage; j++) begin
                s = isva_pkg::div_step(s);
            end
            stage_next[k] = s;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < isva_pkg::DivStages; k++) begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign quotient  = stage_reg[isva_pkg::DivStages-1].quo;
    assign remainder = stage_reg[isva_pkg::DivStages-1].rem;

endmodule

[hdl/int16_stack_vm_alu.sv]
// Signed 16-bit stack vm alu: a six-stage pipeline that takes one word per cycle. Stage one
// takes operand magnitudes and works the simple operations, four divider stages
// each resolve four quotient bits, and the last stage fixes signs and selects the result.
// Throughput is one word per cycle while the pipeline is not stalled, set by the pipelined
// divider. The whole pipeline advances together when the output register is free or being
// read, so s_ready falls only while the output word waits.
module int16_stack_vm_alu (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  isva_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output isva_pkg::out_word_t m_data
);

    localparam int Depth = isva_pkg::DivStages + 2;
    localparam int W = isva_pkg::DataW;

    // per-word side data carried alongside the divider
    typedef struct packed {
        logic [isva_pkg::FuncW-1:0] func;
        logic [W-1:0]               simple;    // result of non-divide operations
        logic                       is_byte;
        logic                       zero_div;
        logic                       neg_quo;
        logic                       neg_rem;
    } side_t;

    logic              advance;
    logic [Depth-1:0]  valid_reg;
    side_t             side_reg [Depth-1];
    side_t             side0_next;
    logic [W-1:0]      mag_l_reg, mag_r_reg;
    logic [W-1:0]      mag_l_next, mag_r_next;
    logic [W-1:0]      quo, rem;
    isva_pkg::out_word_t out_reg, out_next;

    assign advance = !valid_reg[Depth-1] || m_ready;
    assign s_ready = advance;
    assign m_valid = valid_reg[Depth-1];
    assign m_data  = out_reg;

    // stage one: simple operations and magnitudes
    always_comb begin
        logic signed [W-1:0]   l, r;
        logic signed [2*W-1:0] prod;
        logic signed [W-1:0]   amt;
        logic [3:0]            rsh;
        l = s_data.left_operand;
        r = s_data.right_operand;
        prod = l * r;
        amt = W'(s_data.shift_amount);
        rsh = '0;
        side0_next = '0;
        side0_next.func = s_data.func;
        unique case (s_data.func)
            isva_pkg::OP_ADD: side0_next.simple = l + r;
            isva_pkg::OP_SUB: side0_next.simple = l - r;
            isva_pkg::OP_MUL: side0_next.simple = prod[W-1:0];
            isva_pkg::OP_EQ: begin
                side0_next.simple = W'(l == r);
                side0_next.is_byte = 1'b1;
            end
            isva_pkg::OP_GT: begin
                side0_next.simple = W'(l > r);
                side0_next.is_byte = 1'b1;
            end
            isva_pkg::OP_LT: begin
                side0_next.simple = W'(l < r);
                side0_next.is_byte = 1'b1;
            end
            isva_pkg::OP_LE: begin
                side0_next.simple = W'(l <= r);
                side0_next.is_byte = 1'b1;
            end
            isva_pkg::OP_GE: begin
                side0_next.simple = W'(l >= r);
                side0_next.is_byte = 1'b1;
            end
            isva_pkg::OP_NE: begin
                side0_next.simple = W'(l != r);
                side0_next.is_byte = 1'b1;
            end
            isva_pkg::OP_AND: side0_next.simple = l & r;
            isva_pkg::OP_OR:  side0_next.simple = l | r;
            isva_pkg::OP_XOR: side0_next.simple = l ^ r;
            isva_pkg::OP_MIN: side0_next.simple = (l <= r) ? l : r;
            isva_pkg::OP_MAX: side0_next.simple = (l >= r) ? l : r;
            isva_pkg::OP_NOT: side0_next.simple = ~r;
            isva_pkg::OP_ABS: side0_next.simple = r[W-1] ? -r : r;
            isva_pkg::OP_NEG: side0_next.simple = -r;
            isva_pkg::OP_SHIFT: begin
                if (!amt[W-1]) begin
                    side0_next.simple = (amt >= 16) ? '0 : W'(l << amt[3:0]);
                end else begin
                    // right by magnitude, clamped to 15
                    rsh = (amt <= -16'sd15) ? 4'd15 : 4'((-amt));
                    side0_next.simple = l >>> rsh;
                end
            end
            default: side0_next.simple = '0;
        endcase
        side0_next.zero_div = (r == '0) &&
            (s_data.func == isva_pkg::OP_DIV || s_data.func == isva_pkg::OP_MOD);
        side0_next.neg_quo = l[W-1] ^ r[W-1];
        side0_next.neg_rem = l[W-1];
        mag_l_next = l[W-1] ? W'(-l) : l;
        mag_r_next = r[W-1] ? W'(-r) : r;
    end

    isva_div_pipe u_div (
        .aclk      (aclk),
        .en        (advance),
        .dividend  (mag_l_reg),
        .divisor   (mag_r_reg),
        .quotient  (quo),
        .remainder (rem)
    );

    // last stage: sign fixup and result select
    always_comb begin
        side_t t;
        t = side_reg[Depth-2];
        out_next.result_is_byte = t.is_byte;
        out_next.divide_by_zero = t.zero_div;
        if (t.zero_div) begin
            out_next.result_value = '0;
        end else if (t.func == isva_pkg::OP_DIV) begin
            out_next.result_value = t.neg_quo ? -quo : quo;
        end else if (t.func == isva_pkg::OP_MOD) begin
            out_next.result_value = t.neg_rem ? -rem : rem;
        end else begin
            out_next.result_value = t.simple;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= {valid_reg[Depth-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            side_reg[0] <= side0_next;
            for (int k = 1; k < Depth-1; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            mag_l_reg <= mag_l_next;
            mag_r_reg <= mag_r_next;
            out_reg   <= out_next;
        end
    end

endmodule

[tb/tb.sv]
// self-checking testbench for the signed 16-bit stack vm alu
`timescale 1ns / 1ps

module tb;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    isva_pkg::in_word_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    isva_pkg::out_word_t m_data;

    int16_stack_vm_alu dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #10 aclk = ~aclk;

    isva_pkg::out_word_t alu_results_due[$];
    int        error_count = 0;
    bit        stim_done = 1'b0;
    bit        hold_sink = 1'b0;

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    function automatic isva_pkg::out_word_t alu_predict(isva_pkg::in_word_t w);
        isva_pkg::out_word_t o;
        logic signed [15:0] l, r, q;
        logic signed [7:0]  s;
        int               n;
        o = '0;
        l = w.left_operand;
        r = w.right_operand;
        s = w.shift_amount;
        case (w.func)
            isva_pkg::OP_ADD: o.result_value = l + r;
            isva_pkg::OP_SUB: o.result_value = l - r;
            isva_pkg::OP_MUL: o.result_value = l * r;
            isva_pkg::OP_DIV, isva_pkg::OP_MOD: begin
                if (r == 0) begin
                    o.divide_by_zero = 1'b1;
                end else if (l == -16'sd32768 && r == -16'sd1) begin
                    o.result_value = (w.func == isva_pkg::OP_DIV) ? l : 16'sd0;
                end else begin
                    q = l / r;
                    o.result_value = (w.func == isva_pkg::OP_DIV) ? q : l % r;
                end
            end
            isva_pkg::OP_EQ: o.result_value = (l == r);
            isva_pkg::OP_GT: o.result_value = (l > r);
            isva_pkg::OP_LT: o.result_value = (l < r);
            isva_pkg::OP_LE: o.result_value = (l <= r);
            isva_pkg::OP_GE: o.result_value = (l >= r);
            isva_pkg::OP_NE: o.result_value = (l != r);
            isva_pkg::OP_AND: o.result_value = l & r;
            isva_pkg::OP_OR:  o.result_value = l | r;
            isva_pkg::OP_XOR: o.result_value = l ^ r;
            isva_pkg::OP_MIN: o.result_value = (l <= r) ? l : r;
            isva_pkg::OP_MAX: o.result_value = (l >= r) ? l : r;
            isva_pkg::OP_NOT: o.result_value = ~r;
            isva_pkg::OP_ABS: o.result_value = (r < 0) ? -r : r;
            isva_pkg::OP_NEG: o.result_value = -r;
            isva_pkg::OP_SHIFT: begin
                if (s >= 0) begin
                    o.result_value = (s >= 16) ? 16'sd0 : l << s;
                end else begin
                    n = -s;
                    if (n > 15) n = 15;
                    o.result_value = l >>> n;
                end
            end
            default: o = '0;
        endcase
        if (w.func >= isva_pkg::OP_EQ && w.func <= isva_pkg::OP_NE) o.result_is_byte = 1'b1;
        return o;
    endfunction

    // random operand leaning toward the edges
    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            4: return 16'($signed($urandom_range(0, 40)) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_word(input isva_pkg::in_word_t w);
        s_data  <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        alu_results_due.push_back(alu_predict(w));
        @(negedge aclk);
    endtask

    task automatic maybe_gap();
        int g;
        if ($urandom_range(0, 3) == 0) begin
            g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
    endtask

    typedef struct {
        isva_pkg::in_word_t  word;
        bit                  typed;
        isva_pkg::out_word_t result;
    } stim_row_t;

    localparam int NumRows = 22;
    stim_row_t stim_rows [NumRows] = '{
        '{'{isva_pkg::OP_DIV, 16'sd100, 16'sd0, 8'sd0}, 1, '{16'sd0, 1'b0, 1'b1}},
        '{'{isva_pkg::OP_MOD, -16'sd5, 16'sd0, 8'sd3}, 1, '{16'sd0, 1'b0, 1'b1}},
        '{'{isva_pkg::OP_DIV, -16'sd32768, -16'sd1, 8'sd0}, 1,
          '{-16'sd32768, 1'b0, 1'b0}},
        '{'{isva_pkg::OP_MOD, -16'sd32768, -16'sd1, 8'sd0}, 1, '{16'sd0, 1'b0, 1'b0}},
        '{'{isva_pkg::OP_ABS, 16'sd7, -16'sd32768, 8'sd0}, 1, '{-16'sd32768, 1'b0, 1'b0}},
        '{'{isva_pkg::OP_NEG, 16'sd0, -16'sd32768, 8'sd0}, 1, '{-16'sd32768, 1'b0, 1'b0}},
        '{'{isva_pkg::OP_SHIFT, 16'sd1, 16'sd9, 8'sd16}, 1, '{16'sd0, 1'b0, 1'b0}},
        '{'{isva_pkg::OP_SHIFT, -16'sd1, 16'sd0, 8'sd127}, 1, '{16'sd0, 1'b0, 1'b0}},
        '{'{isva_pkg::OP_SHIFT, -16'sd32768, 16'sd0, -8'sd128}, 1,
          '{-16'sd1, 1'b0, 1'b0}},
        '{'{isva_pkg::OP_SHIFT, 16'sd32767, 16'sd0, -8'sd15}, 1, '{16'sd0, 1'b0, 1'b0}},
        '{'{5'd20, 16'sd5, 16'sd5, 8'sd1}, 1, '{16'sd0, 1'b0, 1'b0}},
        '{'{5'd31, -16'sd1, -16'sd1, -8'sd1}, 1, '{16'sd0, 1'b0, 1'b0}},
        '{'{isva_pkg::OP_EQ, -16'sd32768, -16'sd32768, 8'sd0}, 1, '{16'sd1, 1'b1, 1'b0}},
        '{'{isva_pkg::OP_ADD, 16'sd32767, 16'sd1, 8'sd0}, 0, '0},
        '{'{isva_pkg::OP_SUB, -16'sd32768, 16'sd1, 8'sd0}, 0, '0},
        '{'{isva_pkg::OP_MUL, 16'sd32767, 16'sd32767, 8'sd0}, 0, '0},
        '{'{isva_pkg::OP_GT, 16'sd32767, -16'sd32768, 8'sd0}, 0, '0},
        '{'{isva_pkg::OP_LT, 16'sd3, 16'sd3, 8'sd0}, 0, '0},
        '{'{isva_pkg::OP_LE, 16'sd3, 16'sd3, 8'sd0}, 0, '0},
        '{'{isva_pkg::OP_SHIFT, 16'sh1234, 16'sd0, 8'sd15}, 0, '0},
        '{'{isva_pkg::OP_NOT, 16'sd0, 16'sh5a5a, 8'sd0}, 0, '0},
        '{'{isva_pkg::OP_MAX, -16'sd7, 16'sd7, -8'sd1}, 0, '0}
    };

    // result checking against the oldest pending prediction
    always @(posedge aclk) begin
        isva_pkg::out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (alu_results_due.size() == 0) begin
                report($sformatf("unexpected word %h", m_data));
            end else begin
                want = alu_results_due.pop_front();
                if (m_data.result_value !== want.result_value)
                    report($sformatf("result_value %h want %h",
                                     m_data.result_value, want.result_value));
                if (m_data.result_is_byte !== want.result_is_byte)
                    report($sformatf("result_is_byte %b want %b",
                                     m_data.result_is_byte, want.result_is_byte));
                if (m_data.divide_by_zero !== want.divide_by_zero)
                    report($sformatf("divide_by_zero %b want %b",
                                     m_data.divide_by_zero, want.divide_by_zero));
            end
        end
    end

    // sink with random stalls, plus one long hold while the source keeps pushing
    initial begin
        int g;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_sink) begin
                m_ready <= 1'b0;
                repeat (60) @(negedge aclk);
                hold_sink = 1'b0;
            end else if (!stim_done && $urandom_range(0, 4) == 0) begin
                g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
                m_ready <= 1'b0;
                repeat (g - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        isva_pkg::in_word_t w;
        int       idle;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].typed) alu_results_due.push_back(stim_rows[i].result);
            s_data  <= stim_rows[i].word;
            s_valid <= 1'b1;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            if (!stim_rows[i].typed) alu_results_due.push_back(alu_predict(stim_rows[i].word));
            @(negedge aclk);
            maybe_gap();
        end

        for (int k = 0; k < 1900; k++) begin
            if (k == 300) hold_sink = 1'b1;
            if (k == 900) begin
                // drain fully before going on
                s_valid <= 1'b0;
                while (alu_results_due.size() != 0) @(negedge aclk);
            end
            w.func          = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(20, 31))
                                                           : 5'($urandom_range(0, 19));
            w.left_operand  = pick_operand();
            w.right_operand = pick_operand();
            w.shift_amount  = ($urandom_range(0, 1)) ? 8'($urandom)
                                                     : 8'($signed($urandom_range(0, 40)) - 20);
            send_word(w);
            if (k % 200 > 40) maybe_gap();
        end
        s_valid <= 1'b0;
        stim_done = 1'b1;

        idle = 0;
        while (alu_results_due.size() != 0 && idle < 5000) begin
            @(negedge aclk);
            idle++;
        end
        repeat (20) @(negedge aclk);
        if (error_count == 0 && alu_results_due.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb NOT OK");
        $finish;
    end

endmodule
